/* rtl/weighted_3x3_smoothing_filter_core_defines.svh */
// assertion macros shared by the smoothing filter rtl
`ifndef WEIGHTED_3X3_SMOOTHING_FILTER_CORE_DEFINES_SVH
`define WEIGHTED_3X3_SMOOTHING_FILTER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define WSF_ASSERT_SAME(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("wsf assertion failed");
// next-cycle implication
`define WSF_ASSERT_NEXT(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("wsf assertion failed");
`else
`define WSF_ASSERT_SAME(label, ck, rn, ante, cons)
`define WSF_ASSERT_NEXT(label, ck, rn, ante, cons)
`endif
`endif

/* rtl/wsf_pkg.sv */
`timescale 1ns / 1ps
package wsf_pkg;

	// channels per texel, red at index 0
	localparam int NUM_CH = 3;

	// kernel weights scaled by six: centre 1, edges 1/2, corners 1/3
	localparam int CENTRE_WEIGHT = 6;
	localparam int EDGE_WEIGHT   = 3;
	localparam int CORNER_WEIGHT = 2;
	localparam int DIVISOR       = 26;
	localparam int ROUND_BIAS    = DIVISOR / 2;

	// weighted sum grows by at most five bits over one channel
	localparam int SUM_HEADROOM = 5;

	// frame size after reset
	localparam int RESET_SIZE = 512;

	// configuration register indexes
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_BYPASS = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd2;

	// per-word result flags carried down the pipeline
	typedef struct packed {
		logic interior;
		logic border;
		logic last;
	} wsf_flags_t;

endpackage

/* rtl/wsf_linebuf.sv */
`timescale 1ns / 1ps
module wsf_linebuf #(
	parameter int DEPTH = 512,
	parameter int DW    = 48
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DW-1:0]            rd_data_q,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DW-1:0]            wr_data
);

	logic [DW-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read, new data forwarded on a same-address write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_data_q <= wr_data;
			end else begin
				rd_data_q <= mem[rd_addr];
			end
		end
	end

endmodule

/* rtl/wsf_window.sv */
`timescale 1ns / 1ps
module wsf_window #(
	parameter int CHANNEL_BITS = 16
) (
	input  logic                                                  clk,
	input  logic                                                  shift,
	input  logic [wsf_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0]          up1,
	input  logic [wsf_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0]          up2,
	input  logic [wsf_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0]          cur,
	output logic [wsf_pkg::NUM_CH-1:0]
		[CHANNEL_BITS+wsf_pkg::SUM_HEADROOM-1:0]                     sum
);
	import wsf_pkg::*;

	localparam int SW = CHANNEL_BITS + SUM_HEADROOM;

	// two older columns of the 3x3 neighbourhood, top to bottom
	logic [NUM_CH-1:0][CHANNEL_BITS-1:0] win_q [6];

	// shift in the column that just arrived
	always_ff @(posedge clk) begin
		if (shift) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= up2;
			win_q[4] <= up1;
			win_q[5] <= cur;
		end
	end

	// weighted sum per channel
	for (genvar i = 0; i < NUM_CH; i++) begin : g_ch
		logic [SW-1:0] centre;
		logic [SW-1:0] edges;
		logic [SW-1:0] corners;

		assign centre  = SW'(win_q[4][i]);
		assign edges   = SW'(win_q[1][i]) + SW'(up1[i]) + SW'(win_q[3][i]) + SW'(win_q[5][i]);
		assign corners = SW'(win_q[0][i]) + SW'(win_q[2][i]) + SW'(up2[i]) + SW'(cur[i]);
		assign sum[i]  = SW'(CENTRE_WEIGHT) * centre + SW'(EDGE_WEIGHT) * edges
			+ SW'(CORNER_WEIGHT) * corners;
	end

endmodule

/* rtl/wsf_rdiv.sv */
`timescale 1ns / 1ps
module wsf_rdiv #(
	parameter int CHANNEL_BITS = 16
) (
	input  logic                                          clk,
	input  logic                                          en,
	input  logic [CHANNEL_BITS+wsf_pkg::SUM_HEADROOM-1:0] sum,
	output logic [CHANNEL_BITS-1:0]                       quot
);
	import wsf_pkg::*;

	// reciprocal of the divisor, exact for every dividend below 2**SW
	localparam int SW = CHANNEL_BITS + SUM_HEADROOM;
	localparam int K  = SW + $clog2(DIVISOR);
	localparam int MW = K - $clog2(DIVISOR) + 1;
	localparam int PW = SW + MW;
	localparam longint unsigned RECIP_L = ((longint'(1) << K) + DIVISOR - 1) / DIVISOR;
	localparam logic [MW-1:0] RECIP = MW'(RECIP_L);

	logic [SW-1:0] biased;
	logic [PW-1:0] prod_s3;

	// round to nearest, ties up
	assign biased = sum + SW'(ROUND_BIAS);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= PW'(biased) * PW'(RECIP);
		end
	end

	assign quot = prod_s3[K +: CHANNEL_BITS];

endmodule

/* rtl/weighted_3x3_smoothing_filter_core.sv */
`timescale 1ns / 1ps
// 3x3 weighted smoothing over a raster texel stream, one texel per clock unless stalled.
// a texel's result passes stage 1, stage 2, stage 3 and the output register
// throughput: 1 texel per cycle unless stalled; two-result texels stall the words behind
// line buffers use one registered read and one write per cycle
// reset clears the counters, the pipeline valids and the registers (smoothing on, 512x512)
// line buffers and window are not cleared and hold data only once written
`include "weighted_3x3_smoothing_filter_core_defines.svh"
module weighted_3x3_smoothing_filter_core #(
	parameter int MAX_WIDTH    = 512,
	parameter int MAX_HEIGHT   = 512,
	parameter int CHANNEL_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [wsf_pkg::REG_IDX_W-1:0]       cfg_index,
	input  logic [$clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1)-1:0]
		cfg_data,
	input  logic                                texel_valid,
	output logic                                texel_ready,
	input  logic [CHANNEL_BITS-1:0]             red_in,
	input  logic [CHANNEL_BITS-1:0]             green_in,
	input  logic [CHANNEL_BITS-1:0]             blue_in,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic [$clog2(MAX_WIDTH)-1:0]        pixel_x,
	output logic [$clog2(MAX_HEIGHT)-1:0]       pixel_y,
	output logic [CHANNEL_BITS-1:0]             red_out,
	output logic [CHANNEL_BITS-1:0]             green_out,
	output logic [CHANNEL_BITS-1:0]             blue_out,
	output logic                                frame_end
);
	import wsf_pkg::*;

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int SW = CHANNEL_BITS + SUM_HEADROOM;
	localparam int TW = NUM_CH * CHANNEL_BITS;
	localparam int W_RST = (RESET_SIZE > MAX_WIDTH) ? MAX_WIDTH : RESET_SIZE;
	localparam int H_RST = (RESET_SIZE > MAX_HEIGHT) ? MAX_HEIGHT : RESET_SIZE;

	typedef logic [NUM_CH-1:0][CHANNEL_BITS-1:0] texel_t;
	typedef logic [NUM_CH-1:0][SW-1:0] sums_t;

	// configuration, sizes held as clamped last index
	logic          bypass_q;
	logic [XW-1:0] wlast_q;
	logic [YW-1:0] hlast_q;
	logic [XW-1:0] wlast_new;
	logic [YW-1:0] hlast_new;
	logic [WW-1:0] wval;
	logic [HW-1:0] hval;

	assign wval = cfg_data[WW-1:0];
	assign hval = cfg_data[HW-1:0];

	// clamp a written size into 1..max and keep size minus one
	always_comb begin
		if (wval == '0) begin
			wlast_new = '0;
		end else if (wval > WW'(MAX_WIDTH)) begin
			wlast_new = XW'(MAX_WIDTH - 1);
		end else begin
			wlast_new = XW'(wval - WW'(1));
		end
		if (hval == '0) begin
			hlast_new = '0;
		end else if (hval > HW'(MAX_HEIGHT)) begin
			hlast_new = YW'(MAX_HEIGHT - 1);
		end else begin
			hlast_new = YW'(hval - HW'(1));
		end
	end

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bypass_q <= 1'b0;
			wlast_q  <= XW'(W_RST - 1);
			hlast_q  <= YW'(H_RST - 1);
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_BYPASS: bypass_q <= cfg_data[0];
				REG_WIDTH:  wlast_q  <= wlast_new;
				REG_HEIGHT: hlast_q  <= hlast_new;
				default: ;
			endcase
		end
	end

	// pipeline handshake signals
	logic       s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
	logic       s1_adv, s2_adv, s2_free, s3_free, s3_done, out_load;
	logic       accept;
	wsf_flags_t flags_s1, flags_s2, flags_s3;

	assign out_load = s3_valid_q && (!out_valid_q || result_ready);
	assign s3_done  = out_load && !(flags_s3.interior && flags_s3.border);
	assign s3_free  = !s3_valid_q || s3_done;
	assign s2_adv   = s2_valid_q && s3_free;
	assign s2_free  = !s2_valid_q || s2_adv;
	assign s1_adv   = s1_valid_q && s2_free;
	assign texel_ready = !s1_valid_q || s1_adv;
	assign accept   = texel_valid && texel_ready;

	// position of the next texel and what it emits
	logic [XW-1:0] col_q;
	logic [YW-1:0] row_q;
	logic          last_col, last_row, filtering;
	wsf_flags_t    flags_in;

	assign last_col  = col_q >= wlast_q;
	assign last_row  = row_q >= hlast_q;
	assign filtering = !bypass_q && (wlast_q >= XW'(2)) && (hlast_q >= YW'(2));

	always_comb begin
		flags_in.interior = filtering && (col_q >= XW'(2)) && (row_q >= YW'(2))
			&& (col_q <= wlast_q) && (row_q <= hlast_q);
		flags_in.border   = !filtering || (col_q == '0) || (row_q == '0) || last_col || last_row;
		flags_in.last     = last_col && last_row;
	end

	// raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + YW'(1);
			end else begin
				col_q <= col_q + XW'(1);
			end
		end
	end

	// stage 1: input word and line buffer reads
	logic [XW-1:0] x_s1;
	logic [YW-1:0] y_s1;
	texel_t        cur_s1;
	logic [TW-1:0] up1_flat, up2_flat;
	texel_t        up1, up2;
	sums_t         sum_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (texel_ready) begin
			s1_valid_q <= texel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1     <= col_q;
			y_s1     <= row_q;
			cur_s1   <= {blue_in, green_in, red_in};
			flags_s1 <= flags_in;
		end
	end

	wsf_linebuf #(
		.DEPTH (MAX_WIDTH),
		.DW    (TW)
	) u_row_above (
		.clk       (clk),
		.rd_en     (accept),
		.rd_addr   (col_q),
		.rd_data_q (up1_flat),
		.wr_en     (s1_adv),
		.wr_addr   (x_s1),
		.wr_data   (TW'(cur_s1))
	);

	wsf_linebuf #(
		.DEPTH (MAX_WIDTH),
		.DW    (TW)
	) u_row_two_above (
		.clk       (clk),
		.rd_en     (accept),
		.rd_addr   (col_q),
		.rd_data_q (up2_flat),
		.wr_en     (s1_adv),
		.wr_addr   (x_s1),
		.wr_data   (up1_flat)
	);

	assign up1 = texel_t'(up1_flat);
	assign up2 = texel_t'(up2_flat);

	wsf_window #(
		.CHANNEL_BITS (CHANNEL_BITS)
	) u_window (
		.clk   (clk),
		.shift (s1_adv),
		.up1   (up1),
		.up2   (up2),
		.cur   (cur_s1),
		.sum   (sum_s1)
	);

	// stage 2: weighted sums, words with no result are dropped here
	logic [XW-1:0] x_s2;
	logic [YW-1:0] y_s2;
	texel_t        cur_s2;
	sums_t         sum_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (s2_free) begin
			s2_valid_q <= s1_valid_q && (flags_s1.interior || flags_s1.border);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			x_s2     <= x_s1;
			y_s2     <= y_s1;
			cur_s2   <= cur_s1;
			sum_s2   <= sum_s1;
			flags_s2 <= flags_s1;
		end
	end

	// stage 3: rounded division by reciprocal multiply
	texel_t        quot;
	logic [XW-1:0] x_s3;
	logic [YW-1:0] y_s3;
	texel_t        cur_s3;

	for (genvar i = 0; i < NUM_CH; i++) begin : g_div
		wsf_rdiv #(
			.CHANNEL_BITS (CHANNEL_BITS)
		) u_rdiv (
			.clk  (clk),
			.en   (s2_adv),
			.sum  (sum_s2[i]),
			.quot (quot[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_valid_q <= 1'b0;
		end else if (s3_free) begin
			s3_valid_q <= s2_valid_q;
		end
	end

	// interior result goes first, then the border result of the same word
	always_ff @(posedge clk) begin
		if (s2_adv) begin
			x_s3     <= x_s2;
			y_s3     <= y_s2;
			cur_s3   <= cur_s2;
			flags_s3 <= flags_s2;
		end else if (out_load) begin
			flags_s3.interior <= 1'b0;
		end
	end

	// output register
	logic [XW-1:0] o_x, pixel_x_q;
	logic [YW-1:0] o_y, pixel_y_q;
	texel_t        o_tex, tex_q;
	logic          o_end, frame_end_q;

	always_comb begin
		if (flags_s3.interior) begin
			o_x   = x_s3 - XW'(1);
			o_y   = y_s3 - YW'(1);
			o_tex = quot;
			o_end = 1'b0;
		end else begin
			o_x   = x_s3;
			o_y   = y_s3;
			o_tex = cur_s3;
			o_end = flags_s3.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pixel_x_q   <= o_x;
			pixel_y_q   <= o_y;
			tex_q       <= o_tex;
			frame_end_q <= o_end;
		end
	end

	assign result_valid = out_valid_q;
	assign pixel_x      = pixel_x_q;
	assign pixel_y      = pixel_y_q;
	assign red_out      = tex_q[0];
	assign green_out    = tex_q[1];
	assign blue_out     = tex_q[2];
	assign frame_end    = frame_end_q;

	// an interior result needs two rows and two columns of history
	`WSF_ASSERT_SAME(a_int_pos, clk, arst_n, s1_valid_q && flags_s1.interior, (x_s1 >= XW'(2)) && (y_s1 >= YW'(2)))
	// every word in stage 3 still owes a result
	`WSF_ASSERT_SAME(a_s3_work, clk, arst_n, s3_valid_q, flags_s3.interior || flags_s3.border)
	// a word with two results keeps its border result after the first goes out
	`WSF_ASSERT_NEXT(a_s3_split, clk, arst_n, s3_valid_q && flags_s3.interior && flags_s3.border && out_load, s3_valid_q && !flags_s3.interior && flags_s3.border)
	// a stalled stage 2 word is not lost
	`WSF_ASSERT_NEXT(a_s2_hold, clk, arst_n, s2_valid_q && !s3_free, s2_valid_q)

endmodule
